// ===== hw/rtl/csvt_pkg.sv =====
`default_nettype none

package csvt_pkg;

	localparam logic [1:0] KIND_CHAR      = 2'd0;
	localparam logic [1:0] KIND_FIELD_END = 2'd1;
	localparam logic [1:0] KIND_ROW_END   = 2'd2;

	localparam logic [1:0] QS_UNQUOTED   = 2'd0;
	localparam logic [1:0] QS_QUOTED     = 2'd1;
	localparam logic [1:0] QS_QUOTE_SEEN = 2'd2;

	localparam logic [1:0] PH_EMPTY = 2'd0;
	localparam logic [1:0] PH_ONE   = 2'd1;
	localparam logic [1:0] PH_TWO   = 2'd2;
	localparam logic [1:0] PH_DONE  = 2'd3;

	localparam logic OP_DATA = 1'b0;
	localparam logic OP_END  = 1'b1;

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] BOM_0    = 8'hEF;
	localparam logic [7:0] BOM_1    = 8'hBB;
	localparam logic [7:0] BOM_2    = 8'hBF;

	localparam int LANES = 3;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] char_value;
		logic [7:0] field_number;
	} token_t;

endpackage

`default_nettype wire

// ===== hw/rtl/csvt_byte_parser.sv =====
`default_nettype none

module csvt_byte_parser #(
	parameter int FIELD_INDEX_BITS = 8
) (
	input  wire logic                        en,
	input  wire logic [7:0]                  byte_value,
	input  wire logic [1:0]                  quote_i,
	input  wire logic [FIELD_INDEX_BITS-1:0] count_i,
	input  wire logic                        row_open_i,
	output logic      [1:0]                  quote_o,
	output logic      [FIELD_INDEX_BITS-1:0] count_o,
	output logic                             row_open_o,
	output logic                             emit_o,
	output csvt_pkg::token_t                 token_o
);

	logic                        is_lf;
	logic                        is_sep;
	logic                        is_quote;
	logic [FIELD_INDEX_BITS-1:0] count_next;
	logic [7:0]                  field_num;

	assign is_lf    = (byte_value == csvt_pkg::CH_LF);
	assign is_sep   = (byte_value == csvt_pkg::CH_COMMA) || (byte_value == csvt_pkg::CH_SEMI);
	assign is_quote = (byte_value == csvt_pkg::CH_QUOTE);

	// saturating field index
	assign count_next = (count_i != {FIELD_INDEX_BITS{1'b1}}) ?
		count_i + FIELD_INDEX_BITS'(1) : count_i;

	if (FIELD_INDEX_BITS > 8) begin : g_clamp
		assign field_num = (|count_i[FIELD_INDEX_BITS-1:8]) ? 8'hFF : count_i[7:0];
	end else begin : g_extend
		assign field_num = 8'(count_i);
	end

	always_comb begin
		quote_o                = quote_i;
		count_o                = count_i;
		row_open_o             = row_open_i;
		emit_o                 = 1'b0;
		token_o.kind           = csvt_pkg::KIND_CHAR;
		token_o.char_value     = byte_value;
		token_o.field_number   = field_num;
		if (en) begin
			if (is_lf) begin
				emit_o             = 1'b1;
				token_o.kind       = csvt_pkg::KIND_ROW_END;
				token_o.char_value = 8'h00;
				quote_o            = csvt_pkg::QS_UNQUOTED;
				count_o            = '0;
				row_open_o         = 1'b0;
			end else begin
				row_open_o = 1'b1;
				case (quote_i)
					csvt_pkg::QS_QUOTED: begin
						if (is_quote) begin
							quote_o = csvt_pkg::QS_QUOTE_SEEN;
						end else begin
							emit_o = 1'b1;
						end
					end
					csvt_pkg::QS_QUOTE_SEEN: begin
						if (is_sep) begin
							emit_o             = 1'b1;
							token_o.kind       = csvt_pkg::KIND_FIELD_END;
							token_o.char_value = 8'h00;
							count_o            = count_next;
							quote_o            = csvt_pkg::QS_UNQUOTED;
						end else if (is_quote) begin
							emit_o  = 1'b1;
							quote_o = csvt_pkg::QS_QUOTED;
						end else begin
							// stray char after closing quote is dropped
							quote_o = csvt_pkg::QS_UNQUOTED;
						end
					end
					default: begin
						quote_o = csvt_pkg::QS_UNQUOTED;
						if (is_sep) begin
							emit_o             = 1'b1;
							token_o.kind       = csvt_pkg::KIND_FIELD_END;
							token_o.char_value = 8'h00;
							count_o            = count_next;
						end else if (is_quote) begin
							quote_o = csvt_pkg::QS_QUOTED;
						end else begin
							emit_o = 1'b1;
						end
					end
				endcase
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/csvt_step.sv =====
`default_nettype none

module csvt_step #(
	parameter int FIELD_INDEX_BITS = 8
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    advance,
	input  wire logic                    opcode,
	input  wire logic [7:0]              byte_value,
	output logic [csvt_pkg::LANES-1:0]   emit,
	output csvt_pkg::token_t             tokens [csvt_pkg::LANES]
);

	logic [1:0]                  quote_q;
	logic [FIELD_INDEX_BITS-1:0] count_q;
	logic                        row_open_q;
	logic [1:0]                  phase_q;
	logic [15:0]                 mark_buf_q;

	logic [1:0]                  quote_c    [csvt_pkg::LANES+1];
	logic [FIELD_INDEX_BITS-1:0] count_c    [csvt_pkg::LANES+1];
	logic                        row_open_c [csvt_pkg::LANES+1];
	logic [7:0]                  lane_byte  [csvt_pkg::LANES];
	logic [csvt_pkg::LANES-1:0]  lane_en;
	logic                        is_bom;
	logic                        replay;
	logic                        is_end;

	assign is_end = (opcode == csvt_pkg::OP_END);
	assign is_bom = (mark_buf_q == {csvt_pkg::BOM_0, csvt_pkg::BOM_1}) &&
		(byte_value == csvt_pkg::BOM_2);
	assign replay = (phase_q == csvt_pkg::PH_TWO) && !is_bom;

	// lanes 0 and 1 take the held bytes, lane 2 the live byte or the closing row end
	assign lane_byte[0] = mark_buf_q[15:8];
	assign lane_byte[1] = mark_buf_q[7:0];
	assign lane_byte[2] = is_end ? csvt_pkg::CH_LF : byte_value;

	assign lane_en[0] = is_end ?
		((phase_q == csvt_pkg::PH_ONE) || (phase_q == csvt_pkg::PH_TWO)) : replay;
	assign lane_en[1] = is_end ? (phase_q == csvt_pkg::PH_TWO) : replay;
	assign lane_en[2] = is_end ? row_open_c[2] : (replay || (phase_q == csvt_pkg::PH_DONE));

	assign quote_c[0]    = quote_q;
	assign count_c[0]    = count_q;
	assign row_open_c[0] = row_open_q;

	for (genvar i = 0; i < csvt_pkg::LANES; i++) begin : g_lane
		csvt_byte_parser #(
			.FIELD_INDEX_BITS(FIELD_INDEX_BITS)
		) u_parser (
			.en         (lane_en[i]),
			.byte_value (lane_byte[i]),
			.quote_i    (quote_c[i]),
			.count_i    (count_c[i]),
			.row_open_i (row_open_c[i]),
			.quote_o    (quote_c[i+1]),
			.count_o    (count_c[i+1]),
			.row_open_o (row_open_c[i+1]),
			.emit_o     (emit[i]),
			.token_o    (tokens[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quote_q    <= csvt_pkg::QS_UNQUOTED;
			count_q    <= '0;
			row_open_q <= 1'b0;
			phase_q    <= csvt_pkg::PH_EMPTY;
			mark_buf_q <= '0;
		end else if (advance) begin
			if (is_end) begin
				quote_q    <= csvt_pkg::QS_UNQUOTED;
				count_q    <= '0;
				row_open_q <= 1'b0;
				phase_q    <= csvt_pkg::PH_EMPTY;
				mark_buf_q <= '0;
			end else begin
				quote_q    <= quote_c[csvt_pkg::LANES];
				count_q    <= count_c[csvt_pkg::LANES];
				row_open_q <= row_open_c[csvt_pkg::LANES];
				case (phase_q)
					csvt_pkg::PH_EMPTY: begin
						mark_buf_q <= {byte_value, 8'h00};
						phase_q    <= csvt_pkg::PH_ONE;
					end
					csvt_pkg::PH_ONE: begin
						mark_buf_q[7:0] <= byte_value;
						phase_q         <= csvt_pkg::PH_TWO;
					end
					csvt_pkg::PH_TWO: begin
						phase_q <= csvt_pkg::PH_DONE;
					end
					default: begin
						phase_q <= csvt_pkg::PH_DONE;
					end
				endcase
			end
		end
	end

	a_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		advance && is_end |=> phase_q == csvt_pkg::PH_EMPTY && !row_open_q &&
			quote_q == csvt_pkg::QS_UNQUOTED && count_q == '0)
		else $error("end of stream did not restore idle state");

	a_hold_silent: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !is_end &&
			(phase_q == csvt_pkg::PH_EMPTY || phase_q == csvt_pkg::PH_ONE) |-> emit == '0)
		else $error("held byte produced a token");

	a_bom_silent: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !is_end && phase_q == csvt_pkg::PH_TWO && is_bom |-> emit == '0)
		else $error("byte order mark produced a token");

endmodule

`default_nettype wire

// ===== hw/rtl/csvt_result_queue.sv =====
`default_nettype none

module csvt_result_queue (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       load,
	input  wire logic [csvt_pkg::LANES-1:0] load_mask,
	input  wire csvt_pkg::token_t           load_tokens [csvt_pkg::LANES],
	output logic                            load_ready,
	output logic                            token_valid,
	input  wire logic                       token_stall,
	output logic      [1:0]                 token_kind,
	output logic      [7:0]                 char_value,
	output logic      [7:0]                 field_number,
	output logic                            last
);

	logic [csvt_pkg::LANES-1:0] mask_q;
	csvt_pkg::token_t           slot_q [csvt_pkg::LANES];
	logic [csvt_pkg::LANES-1:0] head;
	logic [csvt_pkg::LANES-1:0] rest;
	logic                       pop;
	csvt_pkg::token_t           head_tok;

	assign head        = mask_q & ~(mask_q - csvt_pkg::LANES'(1));
	assign rest        = mask_q & ~head;
	assign token_valid = |mask_q;
	assign pop         = token_valid && !token_stall;
	assign last        = (rest == '0);
	assign load_ready  = (mask_q == '0) || (pop && (rest == '0));

	always_comb begin
		head_tok = '0;
		for (int i = 0; i < csvt_pkg::LANES; i++) begin
			if (head[i]) begin
				head_tok = slot_q[i];
			end
		end
	end

	assign token_kind   = head_tok.kind;
	assign char_value   = head_tok.char_value;
	assign field_number = head_tok.field_number;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (load) begin
			mask_q <= load_mask;
		end else if (pop) begin
			mask_q <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slot_q <= load_tokens;
		end
	end

	a_load_empty: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (mask_q == '0) || (pop && $onehot(mask_q)))
		else $error("new tokens loaded over undelivered ones");

	a_pop_one: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !load |=> $countones(mask_q) == $countones($past(mask_q)) - 1)
		else $error("transfer did not retire exactly one token");

endmodule

`default_nettype wire

// ===== hw/rtl/csv_stream_tokenizer_top.sv =====
// CSV tokenizer: one byte (or end-of-stream mark) per input transfer, giving field
// character, field end and row end tokens with the field index; last marks the final
// token of an item. An input item is taken every cycle while each item gives at most one
// token and the output does not stall; an item that gives more (up to three, on a missing
// byte order mark or at end of stream) stalls the next input while the result queue
// drains one token per cycle unless the output stalls. Each item is registered, then
// loaded into the result queue, which offers its tokens. No clearing pass after reset.
`default_nettype none

module csv_stream_tokenizer_top #(
	parameter int FIELD_INDEX_BITS = 8
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       item_valid,
	output logic            item_stall,
	input  wire logic       opcode,
	input  wire logic [7:0] byte_value,
	output logic            token_valid,
	input  wire logic       token_stall,
	output logic      [1:0] token_kind,
	output logic      [7:0] char_value,
	output logic      [7:0] field_number,
	output logic            last
);

	logic                       valid_s1;
	logic                       opcode_s1;
	logic [7:0]                 byte_s1;
	logic                       load_ready;
	logic                       advance;
	logic                       accept;
	logic [csvt_pkg::LANES-1:0] emit;
	csvt_pkg::token_t           tokens [csvt_pkg::LANES];

	assign advance    = valid_s1 && load_ready;
	assign item_stall = valid_s1 && !load_ready;
	assign accept     = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			opcode_s1 <= opcode;
			byte_s1   <= byte_value;
		end
	end

	csvt_step #(
		.FIELD_INDEX_BITS(FIELD_INDEX_BITS)
	) u_step (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.opcode     (opcode_s1),
		.byte_value (byte_s1),
		.emit       (emit),
		.tokens     (tokens)
	);

	csvt_result_queue u_queue (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (advance),
		.load_mask    (emit),
		.load_tokens  (tokens),
		.load_ready   (load_ready),
		.token_valid  (token_valid),
		.token_stall  (token_stall),
		.token_kind   (token_kind),
		.char_value   (char_value),
		.field_number (field_number),
		.last         (last)
	);

endmodule

`default_nettype wire
